// ----- sv/stereo_flanger_frame_macros.svh -----
// assertion macros for the stereo flanger frame checker
`ifndef STEREO_FLANGER_FRAME_MACROS_SVH
`define STEREO_FLANGER_FRAME_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SFL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flanger check failed");

// property that must hold in the cycle after its trigger
`define SFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flanger check failed");

`endif

// ----- sv/sfl_pkg.sv -----
// package: constants, types and sine table function for the flanger
`timescale 1ns / 1ps
package sfl_pkg;

    localparam int          BUFFER_DEPTH_DEF       = 1024;
    localparam int          SINE_TABLE_ENTRIES_DEF = 256;
    localparam logic [23:0] QUARTER_TURN           = 24'd4194304;
    localparam longint unsigned HALF_PI_Q30        = 64'd1686629713;
    localparam int          FB_LIMIT               = 31130;
    localparam int          LEVEL_MAX              = 32768;

    // register indexes on the config port
    localparam logic [2:0] REG_EFFECT_LEVEL    = 3'd0;
    localparam logic [2:0] REG_MANUAL_DELAY    = 3'd1;
    localparam logic [2:0] REG_DEPTH_SAMPLES   = 3'd2;
    localparam logic [2:0] REG_FEEDBACK_GAIN   = 3'd3;
    localparam logic [2:0] REG_PHASE_INCREMENT = 3'd4;

    typedef struct packed {
        logic [16:0]        level;     // clamped to 32768
        logic [17:0]        manual;
        logic [17:0]        depth;
        logic signed [15:0] fb;        // clamped to +-0.95
        logic [13:0]        inc;
    } sfl_cfg_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic phase;
        logic sine;
        logic depth;
        logic addr;
        logic rd0;
        logic rd1;
        logic interp;
        logic del;
        logic mix;
        logic write;
    } sfl_cmd_t;

    typedef struct packed {
        logic clear_done;
    } sfl_stat_t;

    // one quarter-wave entry from its angle x (Q30 radians), Taylor series
    function automatic logic [14:0] sine_entry(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum * 32767 + (longint'(1) << 29)) >>> 30;
        if (sum > 32767)
        begin
            sum = 32767;
        end
        return 15'(sum);
    endfunction

endpackage

// ----- sv/sfl_ifs.sv -----
// stream interfaces for input frames and output frames
`timescale 1ns / 1ps
interface sfl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sfl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- sv/sfl_cfg.sv -----
// apb register file for the flanger settings
`timescale 1ns / 1ps
module sfl_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output sfl_pkg::sfl_cfg_t cfg
);
    import sfl_pkg::*;

    logic [15:0] effect_level_reg;
    logic [17:0] manual_delay_reg;
    logic [17:0] depth_samples_reg;
    logic [15:0] feedback_gain_reg;
    logic [13:0] phase_increment_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_level_reg    <= 16'd14746;
            manual_delay_reg    <= 18'd22579;
            depth_samples_reg   <= 18'd22579;
            feedback_gain_reg   <= 16'd11469;
            phase_increment_reg <= 14'd160;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_EFFECT_LEVEL:    effect_level_reg    <= pwdata[15:0];
                REG_MANUAL_DELAY:    manual_delay_reg    <= pwdata[17:0];
                REG_DEPTH_SAMPLES:   depth_samples_reg   <= pwdata[17:0];
                REG_FEEDBACK_GAIN:   feedback_gain_reg   <= pwdata[15:0];
                REG_PHASE_INCREMENT: phase_increment_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_EFFECT_LEVEL:    prdata = {16'd0, effect_level_reg};
            REG_MANUAL_DELAY:    prdata = {14'd0, manual_delay_reg};
            REG_DEPTH_SAMPLES:   prdata = {14'd0, depth_samples_reg};
            REG_FEEDBACK_GAIN:   prdata = {16'd0, feedback_gain_reg};
            REG_PHASE_INCREMENT: prdata = {18'd0, phase_increment_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // effective values seen by the datapath
    always_comb
    begin
        cfg.level  = (effect_level_reg > 16'(LEVEL_MAX)) ? 17'(LEVEL_MAX)
                                                          : {1'b0, effect_level_reg};
        cfg.manual = manual_delay_reg;
        cfg.depth  = depth_samples_reg;
        cfg.inc    = phase_increment_reg;
        priority if ($signed(feedback_gain_reg) > 16'sd31130)
            cfg.fb = 16'(FB_LIMIT);
        else if ($signed(feedback_gain_reg) < -16'sd31130)
            cfg.fb = -16'(FB_LIMIT);
        else
            cfg.fb = $signed(feedback_gain_reg);
    end
endmodule

// ----- sv/sfl_ctrl.sv -----
// sequencer that steps one frame through the channel datapaths
`timescale 1ns / 1ps
module sfl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sfl_pkg::sfl_stat_t  stat,
    output sfl_pkg::sfl_cmd_t   cmd
);
    import sfl_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b000000000001,
        ST_IDLE   = 12'b000000000010,
        ST_PHASE  = 12'b000000000100,
        ST_SINE   = 12'b000000001000,
        ST_DEPTH  = 12'b000000010000,
        ST_ADDR   = 12'b000000100000,
        ST_RD0    = 12'b000001000000,
        ST_RD1    = 12'b000010000000,
        ST_INTERP = 12'b000100000000,
        ST_DEL    = 12'b001000000000,
        ST_MIX    = 12'b010000000000,
        ST_WRITE  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PHASE;
                end
            end
            ST_PHASE:  begin cmd.phase  = 1'b1; state_next = ST_SINE;   end
            ST_SINE:   begin cmd.sine   = 1'b1; state_next = ST_DEPTH;  end
            ST_DEPTH:  begin cmd.depth  = 1'b1; state_next = ST_ADDR;   end
            ST_ADDR:   begin cmd.addr   = 1'b1; state_next = ST_RD0;    end
            ST_RD0:    begin cmd.rd0    = 1'b1; state_next = ST_RD1;    end
            ST_RD1:    begin cmd.rd1    = 1'b1; state_next = ST_INTERP; end
            ST_INTERP: begin cmd.interp = 1'b1; state_next = ST_DEL;    end
            ST_DEL:    begin cmd.del    = 1'b1; state_next = ST_MIX;    end
            ST_MIX:    begin cmd.mix    = 1'b1; state_next = ST_WRITE;  end
            ST_WRITE:
            begin
                // hold until the output register can take the frame
                if (out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.write)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- sv/sfl_lane.sv -----
// one channel: lfo phase, sine lookup, delay line memory and mixing
`timescale 1ns / 1ps
module sfl_lane #(
    parameter int          BUFFER_DEPTH       = sfl_pkg::BUFFER_DEPTH_DEF,
    parameter int          SINE_TABLE_ENTRIES = sfl_pkg::SINE_TABLE_ENTRIES_DEF,
    parameter logic [23:0] PHASE_INIT         = 24'd0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfl_pkg::sfl_cmd_t  cmd,
    input  sfl_pkg::sfl_cfg_t  cfg,
    input  logic signed [15:0] dry_in,
    output logic signed [15:0] wet_out,
    output logic               clear_done
);
    import sfl_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW = AW + 10;
    localparam logic signed [23:0] D_LO = 24'sd256;
    localparam logic signed [23:0] D_HI = 24'((BUFFER_DEPTH - 2) * 256);
    localparam logic signed [PW-1:0] SPAN = PW'(BUFFER_DEPTH * 256);
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

    logic [14:0] sine_rom [0:SINE_TABLE_ENTRIES];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_sine
        localparam longint unsigned X = (HALF_PI_Q30 * k) / SINE_TABLE_ENTRIES;
        localparam logic [14:0] V = sine_entry(X);
        assign sine_rom[k] = V;
    end

    logic [17:0] mem [0:BUFFER_DEPTH-1];

    logic [23:0]        phase_reg;
    logic [AW-1:0]      wi_reg;
    logic signed [15:0] dry_reg;
    logic signed [15:0] sin_reg;
    logic signed [34:0] prod_reg;
    logic [AW-1:0]      i0_reg;
    logic [AW-1:0]      i1_reg;
    logic [7:0]         frac_reg;
    logic [17:0]        mem_q_reg;
    logic signed [17:0] rda_reg;
    logic signed [27:0] diff_reg;
    logic signed [17:0] del_reg;
    logic signed [33:0] fbp_reg;
    logic signed [35:0] wetp_reg;
    logic signed [15:0] out_reg;

    logic [34:0]          idx_full;
    logic [IW-1:0]        idx;
    logic [IW-1:0]        rom_addr;
    logic signed [15:0]   sin_val;
    logic signed [34:0]   prod_rnd;
    logic signed [19:0]   dep_term;
    logic signed [23:0]   d_raw;
    logic signed [23:0]   d_clamp;
    logic signed [PW-1:0] pos_raw;
    logic signed [PW-1:0] pos;
    logic [AW-1:0]        i0;
    logic signed [18:0]   diff;
    logic signed [27:0]   dsum;
    logic signed [33:0]   fb_rnd;
    logic signed [35:0]   wet_rnd;
    logic signed [20:0]   line_sum;
    logic signed [21:0]   out_sum;
    logic signed [17:0]   line_val;
    logic signed [15:0]   out_val;
    logic                 mem_we;
    logic [17:0]          mem_wd;
    logic [AW-1:0]        mem_ra;

    // sine of the current phase from the quarter-wave table
    always_comb
    begin
        idx_full = (35'(phase_reg[21:0]) * 35'(SINE_TABLE_ENTRIES)) >> 22;
        idx      = idx_full[IW-1:0];
        rom_addr = phase_reg[22] ? IW'(SINE_TABLE_ENTRIES) - idx : idx;
        sin_val  = phase_reg[23] ? -$signed({1'b0, sine_rom[rom_addr]})
                                 : $signed({1'b0, sine_rom[rom_addr]});
    end

    // delay and read position
    always_comb
    begin
        prod_rnd = prod_reg + 35'sd16384;
        dep_term = prod_rnd[34:15];
        d_raw    = 24'($signed({1'b0, cfg.manual})) + 24'(dep_term);
        priority if (d_raw < D_LO)
            d_clamp = D_LO;
        else if (d_raw > D_HI)
            d_clamp = D_HI;
        else
            d_clamp = d_raw;
        pos_raw = $signed(PW'({wi_reg, 8'd0})) - $signed(PW'(d_clamp));
        pos     = (pos_raw < 0) ? pos_raw + SPAN : pos_raw;
        i0      = pos[AW+7:8];
    end

    // interpolation and mixing
    always_comb
    begin
        diff     = $signed({mem_q_reg[17], mem_q_reg}) - $signed({rda_reg[17], rda_reg});
        dsum     = $signed({{2{rda_reg[17]}}, rda_reg, 8'd0}) + diff_reg + 28'sd128;
        fb_rnd   = fbp_reg + 34'sd16384;
        wet_rnd  = wetp_reg + 36'sd16384;
        line_sum = 21'(dry_reg) + 21'($signed(fb_rnd[33:15]));
        out_sum  = 22'(dry_reg) + 22'($signed(wet_rnd[35:15]));
        priority if (line_sum > 21'sd131071)
            line_val = 18'sd131071;
        else if (line_sum < -21'sd131072)
            line_val = -18'sd131072;
        else
            line_val = line_sum[17:0];
        priority if (out_sum > 22'sd32767)
            out_val = 16'sd32767;
        else if (out_sum < -22'sd32768)
            out_val = -16'sd32768;
        else
            out_val = out_sum[15:0];
    end

    assign mem_we = cmd.clear | cmd.write;
    assign mem_wd = cmd.clear ? 18'd0 : line_val;
    assign mem_ra = cmd.rd1 ? i1_reg : i0_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wi_reg] <= mem_wd;
        if (cmd.rd0 | cmd.rd1)
            mem_q_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_INIT;
            wi_reg    <= '0;
        end
        else
        begin
            if (cmd.phase)
                phase_reg <= phase_reg + {10'd0, cfg.inc};
            if (mem_we)
                wi_reg <= (wi_reg == LAST) ? '0 : wi_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            dry_reg <= dry_in;
        if (cmd.sine)
            sin_reg <= sin_val;
        if (cmd.depth)
            prod_reg <= $signed({1'b0, cfg.depth}) * sin_reg;
        if (cmd.addr)
        begin
            i0_reg   <= i0;
            i1_reg   <= (i0 == LAST) ? '0 : i0 + 1'b1;
            frac_reg <= pos[7:0];
        end
        if (cmd.rd1)
            rda_reg <= $signed(mem_q_reg);
        if (cmd.interp)
            diff_reg <= 28'(diff * $signed({1'b0, frac_reg}));
        if (cmd.del)
            del_reg <= dsum[25:8];
        if (cmd.mix)
        begin
            fbp_reg  <= cfg.fb * del_reg;
            wetp_reg <= $signed({1'b0, cfg.level}) * del_reg;
        end
        if (cmd.write)
            out_reg <= out_val;
    end

    assign wet_out    = out_reg;
    assign clear_done = cmd.clear && (wi_reg == LAST);
endmodule

// ----- sv/stereo_flanger_frame.sv -----
// top level of the stereo flanger: config port, sequencer and two channel lanes
`timescale 1ns / 1ps
// Stereo flanger, one stereo frame per transaction. Each frame steps both LFO
// phases, forms a modulated delay per channel from a quarter-wave sine table,
// reads the delay line with linear interpolation, writes back dry plus
// feedback and returns dry plus wet level, saturated to 16 bits. An accepted
// frame then passes through ten sequencer steps for phase, sine, depth
// multiply, address, two reads of the single delay-line read port,
// interpolation, rounding, gain multiplies, and a write-back step; the next
// frame is accepted in the cycle after write-back. The sequencer works on
// one frame at a time; a finished frame waits in the output register while
// the next one is accepted, and a second finished frame holds the sequencer
// in its write-back step until the first one is taken. After reset the delay
// lines are cleared in one pass over every entry, during which no frame is
// accepted; config writes are taken at any time but belong in gaps where no
// frame is in flight.
module stereo_flanger_frame #(
    parameter int BUFFER_DEPTH       = sfl_pkg::BUFFER_DEPTH_DEF,
    parameter int SINE_TABLE_ENTRIES = sfl_pkg::SINE_TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sfl_in_if.sink      in_ch,
    sfl_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfl_pkg::*;

    sfl_cfg_t  cfg;
    sfl_cmd_t  cmd;
    sfl_stat_t stat;
    logic      clear_done_l;
    logic      clear_done_r;

    // register file, effective gains clamped here
    sfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // both lanes sweep their own write index in step; clear done needs both lanes
    assign stat.clear_done = clear_done_l & clear_done_r;

    // sequencer: owns handshakes and output valid
    sfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // left lane, phase starts at zero
    sfl_lane #(
        .BUFFER_DEPTH       (BUFFER_DEPTH),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .PHASE_INIT         (24'd0)
    ) u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .dry_in     (in_ch.left_in),
        .wet_out    (out_ch.left_out),
        .clear_done (clear_done_l)
    );

    // right lane, phase starts a quarter turn ahead
    sfl_lane #(
        .BUFFER_DEPTH       (BUFFER_DEPTH),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .PHASE_INIT         (QUARTER_TURN)
    ) u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .dry_in     (in_ch.right_in),
        .wet_out    (out_ch.right_out),
        .clear_done (clear_done_r)
    );
endmodule

// ----- sv/sfl_checker.sv -----
// port-level checker for the flanger and its bind to the top level
`timescale 1ns / 1ps
`include "stereo_flanger_frame_macros.svh"
module sfl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] left_out,
    input logic [15:0] right_out,
    input logic        pready
);
    // one frame at a time: no accept right after an accept
    `SFL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    // a result never appears in the cycle right after its frame is taken
    `SFL_ASSERT_NEXT(a_no_fast_result, in_valid && in_ready, !$rose(out_valid))
    // stalled result holds
    `SFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(left_out) && $stable(right_out))
    // config port never waits
    `SFL_ASSERT_NOW(a_pready, 1'b1, pready)
endmodule

bind stereo_flanger_frame sfl_checker u_sfl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .left_out  (out_ch.left_out),
    .right_out (out_ch.right_out),
    .pready    (pready)
);
